// ----- sv/cpic_pkg.sv -----
`timescale 1ns / 1ps

package cpic_pkg;

  // field widths
  localparam int DUTY_W     = 13;
  localparam int CMD_W      = 8;
  localparam int INC_W      = 8;
  localparam int STAGE_W    = 16;
  localparam int COUNT_W    = 18;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // pwm and indicator constants
  localparam int PHASE_WRAP      = 5000;
  localparam int PHASE_INCREMENT = 10;
  localparam int LAMPS_PER_SIDE  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEER_LOW,
    REG_STEER_HIGH,
    REG_STEER_CENTRE,
    REG_SPEED_LOW,
    REG_SPEED_HIGH,
    REG_SPEED_NEUTRAL,
    REG_DUTY_INC,
    REG_STAGE_TICKS
  } reg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_NONE,
    STATUS_FORWARD,
    STATUS_REVERSE,
    STATUS_STOPPED
  } status_e;

  typedef enum logic {
    MODE_CMD,
    MODE_TICK
  } mode_e;

  // command characters
  localparam logic [CMD_W-1:0] CHAR_A_LO = 8'h61;
  localparam logic [CMD_W-1:0] CHAR_A_UP = 8'h41;
  localparam logic [CMD_W-1:0] CHAR_B_LO = 8'h62;
  localparam logic [CMD_W-1:0] CHAR_B_UP = 8'h42;
  localparam logic [CMD_W-1:0] CHAR_C_LO = 8'h63;
  localparam logic [CMD_W-1:0] CHAR_C_UP = 8'h43;
  localparam logic [CMD_W-1:0] CHAR_D_LO = 8'h64;
  localparam logic [CMD_W-1:0] CHAR_D_UP = 8'h44;
  localparam logic [CMD_W-1:0] CHAR_G_LO = 8'h67;
  localparam logic [CMD_W-1:0] CHAR_G_UP = 8'h47;

  // register reset values
  localparam logic [DUTY_W-1:0]  RST_STEER_LOW     = 13'd330;
  localparam logic [DUTY_W-1:0]  RST_STEER_HIGH    = 13'd665;
  localparam logic [DUTY_W-1:0]  RST_STEER_CENTRE  = 13'd480;
  localparam logic [DUTY_W-1:0]  RST_SPEED_LOW     = 13'd420;
  localparam logic [DUTY_W-1:0]  RST_SPEED_HIGH    = 13'd485;
  localparam logic [DUTY_W-1:0]  RST_SPEED_NEUTRAL = 13'd460;
  localparam logic [INC_W-1:0]   RST_DUTY_INC      = 8'd10;
  localparam logic [STAGE_W-1:0] RST_STAGE_TICKS   = 16'd6250;

endpackage

// ----- sv/cpic_cmd_if.sv -----
`timescale 1ns / 1ps

interface cpic_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [cpic_pkg::CMD_W-1:0] cmd_byte;

  modport source (output valid, mode, cmd_byte, input ready);
  modport sink   (input valid, mode, cmd_byte, output ready);
endinterface

// ----- sv/cpic_res_if.sv -----
`timescale 1ns / 1ps

interface cpic_res_if;
  logic                          valid;
  logic                          ready;
  logic                          steer_pin;
  logic                          speed_pin;
  logic [cpic_pkg::LAMPS_PER_SIDE-1:0] left_lamps;
  logic [cpic_pkg::LAMPS_PER_SIDE-1:0] right_lamps;
  logic [cpic_pkg::STATUS_W-1:0] status_code;
  logic                          low_beam;
  logic                          reverse_lamp;
  logic                          brake_lamp;
  logic [cpic_pkg::DUTY_W-1:0]   steer_level;
  logic [cpic_pkg::DUTY_W-1:0]   speed_level;

  modport source (output valid, steer_pin, speed_pin, left_lamps, right_lamps,
                  status_code, low_beam, reverse_lamp, brake_lamp, steer_level,
                  speed_level, input ready);
  modport sink   (input valid, steer_pin, speed_pin, left_lamps, right_lamps,
                  status_code, low_beam, reverse_lamp, brake_lamp, steer_level,
                  speed_level, output ready);
endinterface

// ----- sv/command_pwm_and_indicator_controller.sv -----
`timescale 1ns / 1ps

// Command PWM and indicator controller. Each request is either a received command byte
// (mode 0) or a timer tick (mode 1), and each one gives exactly one result holding every
// output level after that request. Command letters step the steering and speed duties
// within the configured bounds and set the indicator and lamp flags. Ticks advance the
// PWM phase, drive the two pins and run the sequential turn indicators. One request is
// taken every cycle while ready is high: all the work is a single pass of logic from
// the state registers into the result register, and the result appears in the cycle after
// the request is taken. Input ready follows the result register alone: it is high when
// that register is empty or its result is being taken in the same cycle. The user writes
// configuration through the plain write port only while the block is idle (not enforced).

module command_pwm_and_indicator_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpic_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpic_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cpic_cmd_if.sink                        in_i,
  cpic_res_if.source                      out_o
);

  localparam int DW    = cpic_pkg::DUTY_W;
  localparam int LN    = cpic_pkg::LAMPS_PER_SIDE;
  localparam int CW    = cpic_pkg::COUNT_W;
  // stage thresholds reach stage_ticks * (lamps + 1)
  localparam int THR_W = cpic_pkg::STAGE_W + $clog2(LN + 2);
  localparam int CMP_W = (CW > THR_W) ? CW : THR_W;

  typedef struct packed {
    logic [CW-1:0] count;
    logic [LN-1:0] mask;
  } side_t;

  typedef struct packed {
    logic                          steer_pin;
    logic                          speed_pin;
    logic [LN-1:0]                 left_lamps;
    logic [LN-1:0]                 right_lamps;
    logic [cpic_pkg::STATUS_W-1:0] status_code;
    logic                          low_beam;
    logic                          reverse_lamp;
    logic                          brake_lamp;
    logic [DW-1:0]                 steer_level;
    logic [DW-1:0]                 speed_level;
  } res_t;

  // configuration registers
  logic [DW-1:0]                steer_low_q, steer_high_q, steer_centre_q;
  logic [DW-1:0]                speed_low_q, speed_high_q, speed_neutral_q;
  logic [cpic_pkg::INC_W-1:0]   duty_inc_q;
  logic [cpic_pkg::STAGE_W-1:0] stage_ticks_q;

  // block state
  logic [DW-1:0]                 steer_duty_q, steer_duty_d;
  logic [DW-1:0]                 speed_duty_q, speed_duty_d;
  logic [DW-1:0]                 phase_q, phase_d;
  logic                          left_act_q, left_act_d;
  logic                          right_act_q, right_act_d;
  side_t                         left_q, left_d;
  side_t                         right_q, right_d;
  logic [cpic_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          low_beam_q, low_beam_d;
  logic                          reverse_q, reverse_d;
  logic                          brake_q, brake_d;
  logic                          steer_pin_q, steer_pin_d;
  logic                          speed_pin_q, speed_pin_d;

  // result register
  res_t res_q;
  logic out_valid_q;

  logic          in_ready;
  logic          in_accept;
  logic [DW:0]   phase_sum;

  // saturating step up: anything past the ceiling lands on it
  function automatic logic [DW-1:0] step_up(logic [DW-1:0] duty, logic [DW-1:0] ceil_v,
                                            logic [cpic_pkg::INC_W-1:0] inc);
    logic [DW:0] nxt;
    nxt = {1'b0, duty} + (DW + 1)'(inc);
    if (nxt > {1'b0, ceil_v}) begin
      return ceil_v;
    end
    return nxt[DW-1:0];
  endfunction

  // saturating step down: below floor plus step lands on the floor
  function automatic logic [DW-1:0] step_down(logic [DW-1:0] duty, logic [DW-1:0] floor_v,
                                              logic [cpic_pkg::INC_W-1:0] inc);
    logic [DW:0] lim;
    lim = {1'b0, floor_v} + (DW + 1)'(inc);
    if ({1'b0, duty} >= lim) begin
      return duty - DW'(inc);
    end
    return floor_v;
  endfunction

  // one tick of a sequential indicator side
  function automatic side_t run_side(logic active, side_t cur,
                                     logic [cpic_pkg::STAGE_W-1:0] stage);
    side_t        nxt;
    logic         found;
    logic [THR_W-1:0] thr;
    nxt   = cur;
    found = 1'b0;
    if (!active) begin
      nxt.count = '0;
      nxt.mask  = '0;
    end else begin
      nxt.count = cur.count + CW'(1);
      for (int k = 0; k <= LN; k++) begin
        thr = THR_W'(stage) * THR_W'(k + 1);
        if (!found && (CMP_W'(nxt.count) < CMP_W'(thr))) begin
          found = 1'b1;
          if (k < LN) begin
            nxt.mask[k] = 1'b1;
          end else begin
            // stage after the last lamp: clear and restart
            nxt.mask  = '0;
            nxt.count = '0;
          end
        end
      end
    end
    return nxt;
  endfunction

  assign in_ready  = !out_valid_q || out_o.ready;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // phase stays below the wrap, so one subtract brings the sum back into range
  assign phase_sum = {1'b0, phase_q} + (DW + 1)'(cpic_pkg::PHASE_INCREMENT);

  always_comb begin
    steer_duty_d = steer_duty_q;
    speed_duty_d = speed_duty_q;
    phase_d      = phase_q;
    left_act_d   = left_act_q;
    right_act_d  = right_act_q;
    left_d       = left_q;
    right_d      = right_q;
    status_d     = status_q;
    low_beam_d   = low_beam_q;
    reverse_d    = reverse_q;
    brake_d      = brake_q;
    steer_pin_d  = steer_pin_q;
    speed_pin_d  = speed_pin_q;

    if (cpic_pkg::mode_e'(in_i.mode) == cpic_pkg::MODE_TICK) begin
      // pin high while the advanced phase is below the duty
      steer_pin_d = phase_sum < {1'b0, steer_duty_q};
      speed_pin_d = phase_sum < {1'b0, speed_duty_q};
      if (phase_sum >= (DW + 1)'(cpic_pkg::PHASE_WRAP)) begin
        phase_d = DW'(phase_sum - (DW + 1)'(cpic_pkg::PHASE_WRAP));
      end else begin
        phase_d = phase_sum[DW-1:0];
      end
      left_d  = run_side(left_act_q, left_q, stage_ticks_q);
      right_d = run_side(right_act_q, right_q, stage_ticks_q);
    end else begin
      // every command drops the brake first
      brake_d = 1'b0;
      unique case (in_i.cmd_byte)
        cpic_pkg::CHAR_D_LO, cpic_pkg::CHAR_D_UP: begin
          steer_duty_d = step_up(steer_duty_q, steer_high_q, duty_inc_q);
          left_act_d   = 1'b1;
        end
        cpic_pkg::CHAR_B_LO, cpic_pkg::CHAR_B_UP: begin
          steer_duty_d = step_down(steer_duty_q, steer_low_q, duty_inc_q);
          right_act_d  = 1'b1;
        end
        cpic_pkg::CHAR_A_LO, cpic_pkg::CHAR_A_UP: begin
          speed_duty_d = step_up(speed_duty_q, speed_high_q, duty_inc_q);
          status_d     = cpic_pkg::STATUS_FORWARD;
          low_beam_d   = 1'b1;
        end
        cpic_pkg::CHAR_C_LO, cpic_pkg::CHAR_C_UP: begin
          speed_duty_d = step_down(speed_duty_q, speed_low_q, duty_inc_q);
          status_d     = cpic_pkg::STATUS_REVERSE;
          reverse_d    = 1'b1;
        end
        cpic_pkg::CHAR_G_LO, cpic_pkg::CHAR_G_UP: begin
          steer_duty_d = steer_centre_q;
          left_act_d   = 1'b0;
          right_act_d  = 1'b0;
        end
        default: begin
          // unrecognised byte: neutral speed and stop
          speed_duty_d = speed_neutral_q;
          status_d     = cpic_pkg::STATUS_STOPPED;
          low_beam_d   = 1'b0;
          reverse_d    = 1'b0;
          brake_d      = 1'b1;
          left_act_d   = 1'b0;
          right_act_d  = 1'b0;
        end
      endcase
    end
  end

  // configuration port, only data bits that the register holds are kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_low_q     <= cpic_pkg::RST_STEER_LOW;
      steer_high_q    <= cpic_pkg::RST_STEER_HIGH;
      steer_centre_q  <= cpic_pkg::RST_STEER_CENTRE;
      speed_low_q     <= cpic_pkg::RST_SPEED_LOW;
      speed_high_q    <= cpic_pkg::RST_SPEED_HIGH;
      speed_neutral_q <= cpic_pkg::RST_SPEED_NEUTRAL;
      duty_inc_q      <= cpic_pkg::RST_DUTY_INC;
      stage_ticks_q   <= cpic_pkg::RST_STAGE_TICKS;
    end else if (cfg_we_i) begin
      unique case (cpic_pkg::reg_idx_e'(cfg_idx_i))
        cpic_pkg::REG_STEER_LOW:     steer_low_q     <= cfg_data_i[DW-1:0];
        cpic_pkg::REG_STEER_HIGH:    steer_high_q    <= cfg_data_i[DW-1:0];
        cpic_pkg::REG_STEER_CENTRE:  steer_centre_q  <= cfg_data_i[DW-1:0];
        cpic_pkg::REG_SPEED_LOW:     speed_low_q     <= cfg_data_i[DW-1:0];
        cpic_pkg::REG_SPEED_HIGH:    speed_high_q    <= cfg_data_i[DW-1:0];
        cpic_pkg::REG_SPEED_NEUTRAL: speed_neutral_q <= cfg_data_i[DW-1:0];
        cpic_pkg::REG_DUTY_INC:      duty_inc_q      <= cfg_data_i[cpic_pkg::INC_W-1:0];
        cpic_pkg::REG_STAGE_TICKS:   stage_ticks_q   <= cfg_data_i[cpic_pkg::STAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // state advances only on a taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steer_duty_q <= '0;
      speed_duty_q <= '0;
      phase_q      <= '0;
      left_act_q   <= 1'b0;
      right_act_q  <= 1'b0;
      left_q       <= '0;
      right_q      <= '0;
      status_q     <= cpic_pkg::STATUS_NONE;
      low_beam_q   <= 1'b0;
      reverse_q    <= 1'b0;
      brake_q      <= 1'b0;
      steer_pin_q  <= 1'b0;
      speed_pin_q  <= 1'b0;
    end else if (in_accept) begin
      steer_duty_q <= steer_duty_d;
      speed_duty_q <= speed_duty_d;
      phase_q      <= phase_d;
      left_act_q   <= left_act_d;
      right_act_q  <= right_act_d;
      left_q       <= left_d;
      right_q      <= right_d;
      status_q     <= status_d;
      low_beam_q   <= low_beam_d;
      reverse_q    <= reverse_d;
      brake_q      <= brake_d;
      steer_pin_q  <= steer_pin_d;
      speed_pin_q  <= speed_pin_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, loaded with the state after the request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q.steer_pin    <= steer_pin_d;
      res_q.speed_pin    <= speed_pin_d;
      res_q.left_lamps   <= left_d.mask;
      res_q.right_lamps  <= right_d.mask;
      res_q.status_code  <= status_d;
      res_q.low_beam     <= low_beam_d;
      res_q.reverse_lamp <= reverse_d;
      res_q.brake_lamp   <= brake_d;
      res_q.steer_level  <= steer_duty_d;
      res_q.speed_level  <= speed_duty_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.steer_pin    = res_q.steer_pin;
  assign out_o.speed_pin    = res_q.speed_pin;
  assign out_o.left_lamps   = res_q.left_lamps;
  assign out_o.right_lamps  = res_q.right_lamps;
  assign out_o.status_code  = res_q.status_code;
  assign out_o.low_beam     = res_q.low_beam;
  assign out_o.reverse_lamp = res_q.reverse_lamp;
  assign out_o.brake_lamp   = res_q.brake_lamp;
  assign out_o.steer_level  = res_q.steer_level;
  assign out_o.speed_level  = res_q.speed_level;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cpic_pkg::*;

  // every output level after one request
  typedef struct packed {
    logic                      steer_pin;
    logic                      speed_pin;
    logic [LAMPS_PER_SIDE-1:0] left_lamps;
    logic [LAMPS_PER_SIDE-1:0] right_lamps;
    status_e                   status;
    logic                      low_beam;
    logic                      reverse_lamp;
    logic                      brake_lamp;
    logic [DUTY_W-1:0]         steer_level;
    logic [DUTY_W-1:0]         speed_level;
  } levels_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    mode_e                 mode;
    logic [CMD_W-1:0]      data;
    reg_idx_e              sel;
    logic [CFG_DATA_W-1:0] value;
    bit                    typed;
    levels_t               want;
  } plan_row_t;

  localparam int REPORT_LINES    = 40;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 60;
  localparam int DRAIN_CYCLES    = 4;
  localparam int DRAIN_LIMIT     = 10000;

  localparam logic [CMD_W-1:0] LETTERS [10] = '{
    CHAR_A_LO, CHAR_A_UP, CHAR_B_LO, CHAR_B_UP, CHAR_C_LO,
    CHAR_C_UP, CHAR_D_LO, CHAR_D_UP, CHAR_G_LO, CHAR_G_UP
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cpic_cmd_if req_bus ();
  cpic_res_if res_bus ();

  command_pwm_and_indicator_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_bus),
    .out_o      (res_bus)
  );

  always #5 clk_i = ~clk_i;

  // settings as the block should hold them
  logic [DUTY_W-1:0]  steer_low, steer_high, steer_centre;
  logic [DUTY_W-1:0]  speed_low, speed_high, speed_neutral;
  logic [INC_W-1:0]   duty_step;
  logic [STAGE_W-1:0] stage_len;

  // controller state
  logic [DUTY_W-1:0]         steer_duty, speed_duty, pwm_phase;
  logic                      left_on, right_on;
  logic [COUNT_W-1:0]        left_count, right_count;
  logic [LAMPS_PER_SIDE-1:0] left_mask, right_mask;
  status_e                   status_q;
  logic                      low_beam_q, reverse_q, brake_q;
  logic                      steer_pin_q, speed_pin_q;

  levels_t level_queue [$];
  int      mismatches   = 0;
  int      tx_max_gap   = 8;
  int      rx_max_gap   = 8;
  bit      hold_pending = 1'b0;

  function automatic logic [DUTY_W-1:0] duty_up(logic [DUTY_W-1:0] duty,
                                                logic [DUTY_W-1:0] ceiling);
    int next_duty;
    next_duty = int'(duty) + int'(duty_step);
    return (next_duty > int'(ceiling)) ? ceiling : DUTY_W'(next_duty);
  endfunction

  // below floor plus one step snaps to the floor
  function automatic logic [DUTY_W-1:0] duty_down(logic [DUTY_W-1:0] duty,
                                                  logic [DUTY_W-1:0] floor_v);
    if (int'(duty) >= int'(floor_v) + int'(duty_step)) return duty - duty_step;
    return floor_v;
  endfunction

  function automatic void run_lamps(input logic on, inout logic [COUNT_W-1:0] count,
                                    inout logic [LAMPS_PER_SIDE-1:0] mask);
    int limit;
    if (!on) begin
      count = '0;
      mask  = '0;
      return;
    end
    count = count + 1'b1;
    // a zero stage length matches no stage, so the count just runs on
    for (int k = 0; k <= LAMPS_PER_SIDE; k++) begin
      limit = int'(stage_len) * (k + 1);
      if (int'(count) < limit) begin
        if (k < LAMPS_PER_SIDE) begin
          mask = mask | (LAMPS_PER_SIDE'(1) << k);
        end else begin
          mask  = '0;
          count = '0;
        end
        return;
      end
    end
  endfunction

  function automatic levels_t advance_controller(mode_e m, logic [CMD_W-1:0] b);
    int      p;
    levels_t r;
    if (m == MODE_TICK) begin
      p           = int'(pwm_phase) + PHASE_INCREMENT;
      steer_pin_q = (p < int'(steer_duty));
      speed_pin_q = (p < int'(speed_duty));
      pwm_phase   = DUTY_W'(p % PHASE_WRAP);
      run_lamps(left_on, left_count, left_mask);
      run_lamps(right_on, right_count, right_mask);
    end else begin
      brake_q = 1'b0;
      case (b)
        CHAR_D_LO, CHAR_D_UP: begin
          steer_duty = duty_up(steer_duty, steer_high);
          left_on    = 1'b1;
        end
        CHAR_B_LO, CHAR_B_UP: begin
          steer_duty = duty_down(steer_duty, steer_low);
          right_on   = 1'b1;
        end
        CHAR_A_LO, CHAR_A_UP: begin
          speed_duty = duty_up(speed_duty, speed_high);
          status_q   = STATUS_FORWARD;
          low_beam_q = 1'b1;
        end
        CHAR_C_LO, CHAR_C_UP: begin
          speed_duty = duty_down(speed_duty, speed_low);
          status_q   = STATUS_REVERSE;
          reverse_q  = 1'b1;
        end
        CHAR_G_LO, CHAR_G_UP: begin
          steer_duty = steer_centre;
          left_on    = 1'b0;
          right_on   = 1'b0;
        end
        default: begin
          speed_duty = speed_neutral;
          status_q   = STATUS_STOPPED;
          brake_q    = 1'b1;
          low_beam_q = 1'b0;
          reverse_q  = 1'b0;
          left_on    = 1'b0;
          right_on   = 1'b0;
        end
      endcase
    end
    r = '{steer_pin_q, speed_pin_q, left_mask, right_mask, status_q,
          low_beam_q, reverse_q, brake_q, steer_duty, speed_duty};
    return r;
  endfunction

  function automatic plan_row_t req_row(mode_e m, logic [CMD_W-1:0] b);
    plan_row_t row;
    row = '{ROW_REQ, m, b, REG_STEER_LOW, '0, 1'b0, '0};
    return row;
  endfunction

  function automatic plan_row_t fixed_row(mode_e m, logic [CMD_W-1:0] b, levels_t want);
    plan_row_t row;
    row = '{ROW_REQ, m, b, REG_STEER_LOW, '0, 1'b1, want};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(reg_idx_e sel, logic [CFG_DATA_W-1:0] value);
    plan_row_t row;
    row = '{ROW_CFG, MODE_CMD, '0, sel, value, 1'b0, '0};
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < REPORT_LINES)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_levels();
    levels_t want;
    if (level_queue.size() == 0) begin
      report_mismatch("unexpected result", 0, 0);
      return;
    end
    want = level_queue.pop_front();
    if (res_bus.steer_pin !== want.steer_pin)
      report_mismatch("steer_pin", 32'(res_bus.steer_pin), 32'(want.steer_pin));
    if (res_bus.speed_pin !== want.speed_pin)
      report_mismatch("speed_pin", 32'(res_bus.speed_pin), 32'(want.speed_pin));
    if (res_bus.left_lamps !== want.left_lamps)
      report_mismatch("left_lamps", 32'(res_bus.left_lamps), 32'(want.left_lamps));
    if (res_bus.right_lamps !== want.right_lamps)
      report_mismatch("right_lamps", 32'(res_bus.right_lamps), 32'(want.right_lamps));
    if (res_bus.status_code !== want.status)
      report_mismatch("status_code", 32'(res_bus.status_code), 32'(want.status));
    if (res_bus.low_beam !== want.low_beam)
      report_mismatch("low_beam", 32'(res_bus.low_beam), 32'(want.low_beam));
    if (res_bus.reverse_lamp !== want.reverse_lamp)
      report_mismatch("reverse_lamp", 32'(res_bus.reverse_lamp), 32'(want.reverse_lamp));
    if (res_bus.brake_lamp !== want.brake_lamp)
      report_mismatch("brake_lamp", 32'(res_bus.brake_lamp), 32'(want.brake_lamp));
    if (res_bus.steer_level !== want.steer_level)
      report_mismatch("steer_level", 32'(res_bus.steer_level), 32'(want.steer_level));
    if (res_bus.speed_level !== want.speed_level)
      report_mismatch("speed_level", 32'(res_bus.speed_level), 32'(want.speed_level));
  endtask

  // offer one request, then work out its result once it is taken
  task automatic send_req(mode_e m, logic [CMD_W-1:0] b, bit typed, levels_t want);
    int      gap;
    levels_t predicted;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.mode     <= m;
    req_bus.cmd_byte <= b;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    predicted = advance_controller(m, b);
    level_queue.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (level_queue.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e sel, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      REG_STEER_LOW:     steer_low     = value[DUTY_W-1:0];
      REG_STEER_HIGH:    steer_high    = value[DUTY_W-1:0];
      REG_STEER_CENTRE:  steer_centre  = value[DUTY_W-1:0];
      REG_SPEED_LOW:     speed_low     = value[DUTY_W-1:0];
      REG_SPEED_HIGH:    speed_high    = value[DUTY_W-1:0];
      REG_SPEED_NEUTRAL: speed_neutral = value[DUTY_W-1:0];
      REG_DUTY_INC:      duty_step     = value[INC_W-1:0];
      REG_STAGE_TICKS:   stage_len     = value;
    endcase
    @(posedge clk_i);
  endtask

  // mostly ticks and command letters, with some arbitrary bytes
  task automatic send_random(int count);
    int      roll;
    levels_t none;
    none = '0;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 55)
        send_req(MODE_TICK, CMD_W'($urandom_range(0, 255)), 1'b0, none);
      else if (roll < 90)
        send_req(MODE_CMD, LETTERS[$urandom_range(0, 9)], 1'b0, none);
      else
        send_req(MODE_CMD, CMD_W'($urandom_range(0, 255)), 1'b0, none);
    end
  endtask

  // result side: random stalls, and one long hold-off so the block backs up
  initial begin
    int stall;
    res_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, rx_max_gap);
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall        = HOLD_CYCLES;
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (res_bus.valid !== 1'b1);
      check_levels();
    end
  end

  initial begin
    plan_row_t             directed [$];
    logic [CFG_DATA_W-1:0] settings [8];

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_STEER_LOW;
    cfg_data_i       <= '0;
    req_bus.valid    <= 1'b0;
    req_bus.mode     <= MODE_CMD;
    req_bus.cmd_byte <= '0;

    steer_low     = RST_STEER_LOW;
    steer_high    = RST_STEER_HIGH;
    steer_centre  = RST_STEER_CENTRE;
    speed_low     = RST_SPEED_LOW;
    speed_high    = RST_SPEED_HIGH;
    speed_neutral = RST_SPEED_NEUTRAL;
    duty_step     = RST_DUTY_INC;
    stage_len     = RST_STAGE_TICKS;
    steer_duty    = '0;
    speed_duty    = '0;
    pwm_phase     = '0;
    left_on       = 1'b0;
    right_on      = 1'b0;
    left_count    = '0;
    right_count   = '0;
    left_mask     = '0;
    right_mask    = '0;
    status_q      = STATUS_NONE;
    low_beam_q    = 1'b0;
    reverse_q     = 1'b0;
    brake_q       = 1'b0;
    steer_pin_q   = 1'b0;
    speed_pin_q   = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unknown bytes stop the car straight after reset
    directed.push_back(fixed_row(MODE_CMD, 8'hFF, levels_t'{1'b0, 1'b0, 4'h0, 4'h0,
        STATUS_STOPPED, 1'b0, 1'b0, 1'b1, 13'd0, 13'd460}));
    directed.push_back(fixed_row(MODE_CMD, 8'h00, levels_t'{1'b0, 1'b0, 4'h0, 4'h0,
        STATUS_STOPPED, 1'b0, 1'b0, 1'b1, 13'd0, 13'd460}));
    directed.push_back(fixed_row(MODE_TICK, 8'h00, levels_t'{1'b0, 1'b1, 4'h0, 4'h0,
        STATUS_STOPPED, 1'b0, 1'b0, 1'b1, 13'd0, 13'd460}));
    // speed up into the ceiling, then back down
    directed.push_back(req_row(MODE_CMD, CHAR_A_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_A_UP));
    directed.push_back(req_row(MODE_CMD, CHAR_A_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_C_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_C_UP));
    // steering from zero: a step down lands on the floor
    directed.push_back(req_row(MODE_CMD, CHAR_B_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_D_UP));
    directed.push_back(req_row(MODE_CMD, CHAR_D_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_B_UP));
    directed.push_back(req_row(MODE_CMD, CHAR_G_UP));
    // one tick per stage, both indicators lighting lamps 1 to 3 in turn, then clearing and restarting
    directed.push_back(cfg_row(REG_STAGE_TICKS, 16'd1));
    directed.push_back(req_row(MODE_CMD, CHAR_D_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_B_LO));
    repeat (5) directed.push_back(req_row(MODE_TICK, 8'hFF));
    // centre above the ceiling: a step up falls back to the ceiling
    directed.push_back(cfg_row(REG_STEER_CENTRE, 16'd5000));
    directed.push_back(cfg_row(REG_STEER_HIGH, 16'd100));
    directed.push_back(req_row(MODE_CMD, CHAR_G_LO));
    directed.push_back(req_row(MODE_CMD, CHAR_D_LO));
    // zero stage length keeps the lamps as they are, until an unknown byte stops the indicators
    directed.push_back(cfg_row(REG_STAGE_TICKS, 16'd0));
    directed.push_back(req_row(MODE_TICK, 8'h00));
    directed.push_back(req_row(MODE_TICK, 8'h55));
    directed.push_back(req_row(MODE_CMD, 8'h71));
    directed.push_back(req_row(MODE_TICK, 8'hAA));

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed[i].sel, directed[i].value);
      end else begin
        send_req(directed[i].mode, directed[i].data, directed[i].typed, directed[i].want);
      end
    end

    // random phases: reset values, both extremes, then random settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: settings = '{RST_STEER_LOW, RST_STEER_HIGH, RST_STEER_CENTRE, RST_SPEED_LOW,
                        RST_SPEED_HIGH, RST_SPEED_NEUTRAL, RST_DUTY_INC, RST_STAGE_TICKS};
        1: settings = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1};
        2: settings = '{16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000, 16'd5000,
                        16'd255, 16'd65535};
        default: begin
          for (int r = 0; r < 6; r++) settings[r] = CFG_DATA_W'($urandom_range(0, 5000));
          settings[6] = CFG_DATA_W'($urandom_range(1, 255));
          // short stages mostly, so the indicators run their whole sequence
          if ($urandom_range(0, 3) == 0)
            settings[7] = CFG_DATA_W'($urandom_range(1, 65535));
          else
            settings[7] = CFG_DATA_W'($urandom_range(1, 12));
        end
      endcase
      wait_idle();
      for (int r = 0; r < 8; r++) write_reg(reg_idx_e'(r), settings[r]);
      tx_max_gap   = (ph == 0 || ph == 4) ? 0 : 8;
      rx_max_gap   = (ph == 0 || ph == 5) ? 0 : 8;
      hold_pending = (ph == 3);
      send_random(ITEMS_PER_PHASE);
    end

    req_bus.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && level_queue.size() != 0; n++) @(posedge clk_i);
    if (level_queue.size() != 0)
      report_mismatch("results still outstanding", level_queue.size(), 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
